FILE: design/afk_pkg.sv
// Shared types, constants and helpers for the arm forward kinematics pipeline.
`default_nettype none
package afk_pkg;

  localparam int JOINT_CNT    = 7;
  localparam int CORDIC_STEPS = 16;
  localparam int JOINT_SLOTS  = 7;
  localparam int ATAN_SLOTS   = 24;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [33:0] zq_t;
  typedef logic signed [32:0] cs_t;
  typedef logic signed [33:0] mq_t;
  typedef logic signed [66:0] prod_t;
  typedef logic signed [67:0] sum_t;
  typedef logic signed [51:0] lprod_t;
  typedef logic signed [55:0] acc_t;
  typedef mq_t  mat_t [3][3];
  typedef acc_t vec_t [3];

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] REG_BASE_X   = 2'd0;
  localparam logic [1:0] REG_BASE_Y   = 2'd1;
  localparam logic [1:0] REG_BASE_Z   = 2'd2;
  localparam logic [1:0] REG_HAND_LEN = 2'd3;

  localparam logic signed [17:0] BASE_X_RST   = -18'sd16384;
  localparam logic signed [17:0] BASE_Y_RST   = 18'sd0;
  localparam logic signed [17:0] BASE_Z_RST   = 18'sd16384;
  localparam logic [16:0]        HAND_LEN_RST = 17'd3277;

  localparam zq_t Q30_GAIN    = 34'sd652032874;
  localparam zq_t Q30_PI      = 34'sd3373259426;
  localparam zq_t Q30_HALF_PI = 34'sd1686629713;
  localparam mq_t Q30_ONE     = 34'sd1073741824;

  localparam logic signed [25:0] POS_MAX = 26'sd131071;
  localparam logic signed [25:0] POS_MIN = -26'sd131072;

  localparam zq_t ATAN_TAB [ATAN_SLOTS] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76, 34'sh01FFD55B,
    34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
    34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF,
    34'sh00000FFF, 34'sh000007FF, 34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
  };

  localparam logic [1:0] JOINT_AXIS [JOINT_SLOTS] = '{
    AXIS_Z, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X
  };
  localparam logic [16:0] LINK_LEN [JOINT_SLOTS] = '{
    17'd3834, 17'd7176, 17'd4358, 17'd6455, 17'd4080, 17'd4080, 17'd4866
  };
  localparam ang_t LIM_LO [JOINT_SLOTS] = '{
    -16'sd13153, -16'sd10008, -16'sd25735, -16'sd18444, -16'sd25735, -16'sd17872, -16'sd25735
  };
  localparam ang_t LIM_HI [JOINT_SLOTS] = '{
    16'sd13153, 16'sd12439, 16'sd25735, 16'sd18444, 16'sd25735, 16'sd17872, 16'sd25735
  };

  // round half up and drop 30 fraction bits
  function automatic mq_t rnd30(input sum_t v);
    sum_t t;
    t = v + (sum_t'(1) <<< 29);
    return t[63:30];
  endfunction

endpackage
`default_nettype wire

FILE: design/afk_cordic.sv
// Pipelined rotation-mode CORDIC giving Q.30 cosine and sine of a Q2.13 angle.
`default_nettype none
module afk_cordic import afk_pkg::*; (
  input  wire  clk,
  input  wire  en,
  input  ang_t angle,
  output cs_t  cos_val,
  output cs_t  sin_val
);

  zq_t  z_r   [CORDIC_STEPS+1];
  cs_t  x_r   [CORDIC_STEPS+1];
  cs_t  y_r   [CORDIC_STEPS+1];
  logic neg_r [CORDIC_STEPS+1];
  zq_t  zin;
  zq_t  z_nxt;
  logic neg_nxt;

  always_comb begin
    zin = zq_t'(angle) <<< 17;
    if (zin > Q30_HALF_PI) begin
      z_nxt   = zin - Q30_PI;
      neg_nxt = 1'b1;
    end else if (zin < -Q30_HALF_PI) begin
      z_nxt   = zin + Q30_PI;
      neg_nxt = 1'b1;
    end else begin
      z_nxt   = zin;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z_nxt;
      neg_r[0] <= neg_nxt;
      x_r[0]   <= cs_t'(Q30_GAIN);
      y_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_val <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire

FILE: design/afk_joint.sv
// One joint: two-stage rotation of the running matrix plus the previous link's position step.
`default_nettype none
module afk_joint import afk_pkg::*; (
  input  wire         clk,
  input  wire         en,
  input  logic [1:0]  axis,
  input  logic [16:0] len_prev,
  input  cs_t         c,
  input  cs_t         s,
  input  mat_t        m_in,
  input  vec_t        acc_in,
  output mat_t        m_out,
  output vec_t        acc_out
);

  prod_t      pa_r [3];
  prod_t      pb_r [3];
  prod_t      pc_r [3];
  prod_t      pd_r [3];
  mq_t        keep_r [3];
  lprod_t     lp_r [3];
  vec_t       acc_r;
  logic [1:0] ia;
  logic [1:0] ib;
  logic [1:0] ik;
  mat_t       m_nxt;
  sum_t       sa;
  sum_t       sb;

  always_comb begin
    case (axis)
      AXIS_Z: begin
        ia = 2'd0; ib = 2'd1; ik = 2'd2;
      end
      AXIS_Y: begin
        ia = 2'd0; ib = 2'd2; ik = 2'd1;
      end
      default: begin
        ia = 2'd1; ib = 2'd2; ik = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pa_r[r]   <= m_in[r][ia] * c;
        pb_r[r]   <= m_in[r][ib] * s;
        pc_r[r]   <= m_in[r][ib] * c;
        pd_r[r]   <= m_in[r][ia] * s;
        keep_r[r] <= m_in[r][ik];
        lp_r[r]   <= m_in[r][0] * $signed({1'b0, len_prev});
        acc_r[r]  <= acc_in[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // about Y the sine enters with the opposite sign
      if (axis == AXIS_Y) begin
        sa = sum_t'(pa_r[r]) - sum_t'(pb_r[r]);
        sb = sum_t'(pc_r[r]) + sum_t'(pd_r[r]);
      end else begin
        sa = sum_t'(pa_r[r]) + sum_t'(pb_r[r]);
        sb = sum_t'(pc_r[r]) - sum_t'(pd_r[r]);
      end
      m_nxt[r][ia] = rnd30(sa);
      m_nxt[r][ib] = rnd30(sb);
      m_nxt[r][ik] = keep_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_out <= m_nxt;
      for (int r = 0; r < 3; r++) begin
        acc_out[r] <= acc_r[r] + acc_t'(lp_r[r]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/arm_forward_kinematics.sv
// Throughput: one item per cycle while the result side does not stall; set by the
// CORDIC stages and the two-stage rotation per joint, all fully pipelined.
// A stall on the result side freezes the whole pipeline and the input stalls with it.
// Synchronous active-low reset clears the valid bits and loads the register reset values.
`default_nettype none
module arm_forward_kinematics import afk_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  ang_t               in_angle_pan,
  input  ang_t               in_angle_lift,
  input  ang_t               in_angle_upper_roll,
  input  ang_t               in_angle_elbow,
  input  ang_t               in_angle_fore_roll,
  input  ang_t               in_angle_wrist_flex,
  input  ang_t               in_angle_wrist_roll,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [17:0] out_pos_x,
  output logic signed [17:0] out_pos_y,
  output logic signed [17:0] out_pos_z,
  output logic               out_in_limits,
  input  wire                cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [17:0]        cfg_data
);

  localparam int CSTG = CORDIC_STEPS + 2;
  localparam int LAT  = CSTG + 2 * JOINT_CNT + 3;

  logic signed [17:0] base_x_r;
  logic signed [17:0] base_y_r;
  logic signed [17:0] base_z_r;
  logic [16:0]        hand_len_r;

  logic               en;
  logic [LAT-1:0]     v_r;
  logic [LAT-1:0]     ok_r;
  logic               ok_nxt;
  ang_t               ang [JOINT_SLOTS];
  mat_t               m_chain [JOINT_CNT+1];
  vec_t               acc_chain [JOINT_CNT+1];

  lprod_t             hp_r [3];
  lprod_t             lk_r [3];
  vec_t               accf_r;
  vec_t               accs_r;
  logic signed [17:0] pos_nxt [3];
  acc_t               t;

  assign en       = !(v_r[LAT-1] && out_stall);
  assign in_stall = !en;

  assign ang[0] = in_angle_pan;
  assign ang[1] = in_angle_lift;
  assign ang[2] = in_angle_upper_roll;
  assign ang[3] = in_angle_elbow;
  assign ang[4] = in_angle_fore_roll;
  assign ang[5] = in_angle_wrist_flex;
  assign ang[6] = in_angle_wrist_roll;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r   <= BASE_X_RST;
      base_y_r   <= BASE_Y_RST;
      base_z_r   <= BASE_Z_RST;
      hand_len_r <= HAND_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE_X:   base_x_r   <= cfg_data;
        REG_BASE_Y:   base_y_r   <= cfg_data;
        REG_BASE_Z:   base_z_r   <= cfg_data;
        REG_HAND_LEN: hand_len_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ok_nxt = 1'b1;
    for (int j = 0; j < JOINT_CNT; j++) begin
      if (ang[j] < LIM_LO[j] || ang[j] > LIM_HI[j]) ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) ok_r <= {ok_r[LAT-2:0], ok_nxt};
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) m_chain[0][r][k] = (r == k) ? Q30_ONE : '0;
    end
    acc_chain[0][0] = acc_t'(base_x_r) <<< 30;
    acc_chain[0][1] = acc_t'(base_y_r) <<< 30;
    acc_chain[0][2] = acc_t'(base_z_r) <<< 30;
  end

  for (genvar j = 0; j < JOINT_CNT; j++) begin : g_joint
    cs_t cd [2*j+1];
    cs_t sd [2*j+1];

    afk_cordic u_cordic (
      .clk     (clk),
      .en      (en),
      .angle   (ang[j]),
      .cos_val (cd[0]),
      .sin_val (sd[0])
    );

    // line the angle up with the joint's place in the chain
    for (genvar k = 1; k <= 2*j; k++) begin : g_dly
      always_ff @(posedge clk) begin
        if (en) begin
          cd[k] <= cd[k-1];
          sd[k] <= sd[k-1];
        end
      end
    end

    afk_joint u_joint (
      .clk      (clk),
      .en       (en),
      .axis     (JOINT_AXIS[j]),
      .len_prev ((j == 0) ? 17'd0 : LINK_LEN[(j == 0) ? 0 : j-1]),
      .c        (cd[2*j]),
      .s        (sd[2*j]),
      .m_in     (m_chain[j]),
      .acc_in   (acc_chain[j]),
      .m_out    (m_chain[j+1]),
      .acc_out  (acc_chain[j+1])
    );
  end

  // last link and hand along the final local x
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        hp_r[r]   <= m_chain[JOINT_CNT][r][0] * $signed({1'b0, hand_len_r});
        lk_r[r]   <= m_chain[JOINT_CNT][r][0] * $signed({1'b0, LINK_LEN[JOINT_CNT-1]});
        accf_r[r] <= acc_chain[JOINT_CNT][r];
        accs_r[r] <= accf_r[r] + acc_t'(hp_r[r]) + acc_t'(lk_r[r]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t = (accs_r[r] + (acc_t'(1) <<< 29)) >>> 30;
      if (t > acc_t'(POS_MAX)) pos_nxt[r] = POS_MAX[17:0];
      else if (t < acc_t'(POS_MIN)) pos_nxt[r] = POS_MIN[17:0];
      else pos_nxt[r] = t[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x <= pos_nxt[0];
      out_pos_y <= pos_nxt[1];
      out_pos_z <= pos_nxt[2];
    end
  end

  assign out_valid     = v_r[LAT-1];
  assign out_in_limits = ok_r[LAT-1];

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the arm forward kinematics pipeline.
`timescale 1ns / 100ps
module tb_top import afk_pkg::*; ;

  typedef struct packed {
    ang_t [6:0] ang;
  } pose_t;

  typedef struct packed {
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [17:0] pz;
    logic               ok;
  } tip_t;

  localparam int STALL_HOLD = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ang_t in_ang [7];
  logic out_valid;
  logic out_stall;
  logic signed [17:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_in_limits;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [17:0] cfg_data;

  arm_forward_kinematics u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_pan(in_ang[0]), .in_angle_lift(in_ang[1]),
    .in_angle_upper_roll(in_ang[2]), .in_angle_elbow(in_ang[3]),
    .in_angle_fore_roll(in_ang[4]), .in_angle_wrist_flex(in_ang[5]),
    .in_angle_wrist_roll(in_ang[6]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_in_limits(out_in_limits),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pose_t pose_q[$];
  tip_t  tip_q[$];
  int    err_cnt = 0;
  int    tip_cnt = 0;
  int    in_cnt  = 0;
  int    send_idle = 13;
  int    recv_idle = 46;
  int    hold_left = 0;
  bit    hold_req  = 0;

  logic signed [17:0] mdl_bx, mdl_by, mdl_bz;
  logic [16:0]        mdl_hand;

  localparam longint Q_ONE = 64'sd1 <<< 30;
  localparam int LINK [7] = '{3834, 7176, 4358, 6455, 4080, 4080, 4866};
  localparam int LO [7] = '{-13153, -10008, -25735, -18444, -25735, -17872, -25735};
  localparam int HI [7] = '{13153, 12439, 25735, 18444, 25735, 17872, 25735};
  localparam longint ATAN [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void joint_sincos(input int ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clip_pos(longint acc);
    longint v;
    v = round_q30(acc);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v;
  endfunction

  function automatic tip_t solve_pose(pose_t p);
    longint m [3][3];
    longint acc [3];
    longint c, s, va, vb;
    int a, b, ang;
    tip_t t;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) m[r][k] = (r == k) ? Q_ONE : 0;
    acc[0] = longint'(mdl_bx) * Q_ONE;
    acc[1] = longint'(mdl_by) * Q_ONE;
    acc[2] = longint'(mdl_bz) * Q_ONE;
    t.ok = 1;
    for (int j = 0; j < 7; j++) begin
      ang = p.ang[j];
      if (ang < LO[j] || ang > HI[j]) t.ok = 0;
      joint_sincos(ang, c, s);
      case (JOINT_AXIS[j])
        AXIS_Z: begin a = 0; b = 1; end
        AXIS_Y: begin a = 0; b = 2; s = -s; end
        default: begin a = 1; b = 2; end
      endcase
      for (int r = 0; r < 3; r++) begin
        va = m[r][a]; vb = m[r][b];
        m[r][a] = round_q30(va * c + vb * s);
        m[r][b] = round_q30(vb * c - va * s);
      end
      for (int r = 0; r < 3; r++) acc[r] += m[r][0] * LINK[j];
    end
    for (int r = 0; r < 3; r++) acc[r] += m[r][0] * longint'(mdl_hand);
    t.px = 18'(clip_pos(acc[0]));
    t.py = 18'(clip_pos(acc[1]));
    t.pz = 18'(clip_pos(acc[2]));
    return t;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s at result %0d: got %0d want %0d", what, tip_cnt, got, want);
    err_cnt++;
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tip_q = {tip_q, solve_pose({in_ang[6], in_ang[5], in_ang[4], in_ang[3],
                                    in_ang[2], in_ang[1], in_ang[0]})};
        in_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pose_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          pose_t p;
          p = pose_q.pop_front();
          for (int j = 0; j < 7; j++) in_ang[j] <= p.ang[j];
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= STALL_HOLD;
      hold_req = 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tip_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          tip_t w;
          w = tip_q.pop_front();
          if (out_pos_x !== w.px) report_mismatch("pos_x", out_pos_x, w.px);
          if (out_pos_y !== w.py) report_mismatch("pos_y", out_pos_y, w.py);
          if (out_pos_z !== w.pz) report_mismatch("pos_z", out_pos_z, w.pz);
          if (out_in_limits !== w.ok) report_mismatch("in_limits", out_in_limits, w.ok);
        end
        tip_cnt++;
      end
      if (hold_left > 0) begin
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  function automatic pose_t rand_pose(bit wide);
    pose_t p;
    for (int j = 0; j < 7; j++)
      p.ang[j] = wide ? ang_t'($urandom) : ang_t'($urandom_range(2 * HI[j]) - HI[j]);
    return p;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_BASE_X: mdl_bx = val;
      REG_BASE_Y: mdl_by = val;
      REG_BASE_Z: mdl_bz = val;
      default:    mdl_hand = val[16:0];
    endcase
  endtask

  task automatic drain;
    while (pose_q.size() > 0 || in_valid || tip_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_batch(input int n);
    for (int k = 0; k < n; k++) pose_q = {pose_q, rand_pose($urandom_range(3) == 0)};
    drain();
  endtask

  initial begin
    pose_t p;
    int ext [6];
    ext = '{-32768, 32767, 0, -1, 25736, -25736};
    rst_n = 0; in_valid = 0; cfg_we = 0; cfg_idx = REG_BASE_X; cfg_data = 0;
    out_stall = 0;
    for (int j = 0; j < 7; j++) in_ang[j] = 0;
    mdl_bx = BASE_X_RST; mdl_by = BASE_Y_RST; mdl_bz = BASE_Z_RST; mdl_hand = HAND_LEN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, limit edges, half-pi wrap
    foreach (ext[e]) begin
      for (int j = 0; j < 7; j++) p.ang[j] = ang_t'(ext[e]);
      pose_q = {pose_q, p};
    end
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'(LO[j]);
    pose_q = {pose_q, p};
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'(HI[j]);
    pose_q = {pose_q, p};
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'(LO[j] - 1);
    pose_q = {pose_q, p};
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'(HI[j] + 1);
    pose_q = {pose_q, p};
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'((j % 2) ? 12868 : -12868);
    pose_q = {pose_q, p};
    for (int j = 0; j < 7; j++) p.ang[j] = ang_t'((j % 2) ? 12867 : 12869);
    pose_q = {pose_q, p};
    drain();

    write_reg(REG_BASE_X, 18'h1FFFF);
    write_reg(REG_BASE_Y, 18'h20000);
    write_reg(REG_BASE_Z, 18'h1FFFF);
    write_reg(REG_HAND_LEN, 18'h1FFFF);
    run_batch(150);
    write_reg(REG_BASE_X, 18'h20000);
    write_reg(REG_BASE_Y, 18'h1FFFF);
    write_reg(REG_BASE_Z, 18'h20000);
    write_reg(REG_HAND_LEN, 18'h3FFFF);
    run_batch(150);
    write_reg(REG_HAND_LEN, 18'h0);
    write_reg(REG_BASE_X, 18'h0);
    write_reg(REG_BASE_Z, 18'h0);
    run_batch(150);

    send_idle = 46; recv_idle = 13;
    write_reg(REG_BASE_X, 18'($urandom)); write_reg(REG_BASE_Y, 18'($urandom));
    write_reg(REG_BASE_Z, 18'($urandom)); write_reg(REG_HAND_LEN, 18'($urandom));
    for (int k = 0; k < 200; k++) pose_q = {pose_q, rand_pose($urandom_range(3) == 0)};
    repeat (50) @(posedge clk);
    hold_req = 1;
    drain();

    send_idle = 0; recv_idle = 0;
    write_reg(REG_BASE_X, BASE_X_RST); write_reg(REG_BASE_Y, BASE_Y_RST);
    write_reg(REG_BASE_Z, BASE_Z_RST); write_reg(REG_HAND_LEN, 18'(HAND_LEN_RST));
    for (int k = 0; k < 480; k++) pose_q = {pose_q, rand_pose($urandom_range(3) == 0)};
    repeat (30) @(posedge clk);
    hold_req = 1;
    drain();

    $display("covered %0d poses and %0d results over five register settings,", in_cnt, tip_cnt);
    $display("with wrap-round angles, joint limit edges and a long output hold-off");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
